[src/fmal_pkg.sv]
// Shared types and constants for the first-match access limiter.
// Used by fmal_rule_scan, first_match_access_limiter, fmal_verdict_monitor and the testbench; no dependencies.
package fmal_pkg;

  localparam int RULE_COUNT  = 64;
  localparam int CLASS_COUNT = 16;
  localparam int RULE_IDX_W  = 6;
  localparam int CLASS_IDX_W = 4;
  localparam int CNT_W       = 31;

  // commands carried in s_tuser
  typedef enum logic [2:0] {
    CMD_LOAD_RULE  = 3'd0,
    CMD_LOAD_CLASS = 3'd1,
    CMD_CHECK      = 3'd2,
    CMD_RECOUNT    = 3'd3,
    CMD_RELEASE    = 3'd4
  } cmd_t;

  // result codes carried in m_tuser
  typedef enum logic [1:0] {
    ST_GRANT = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  // one rule table entry
  typedef struct packed {
    logic [31:0]            addr;
    logic [31:0]            mask;
    logic [23:0]            hours;
    logic [6:0]             days;
    logic                   timed;
    logic [CLASS_IDX_W-1:0] cls;
  } rule_t;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [6:0]  pad;
    logic [2:0]  weekday_now;
    logic [4:0]  hour_now;
    logic [30:0] class_limit;
    logic [3:0]  rule_class;
    logic        time_check;
    logic [6:0]  day_set;
    logic [23:0] hour_set;
    logic [31:0] addr_mask;
    logic [31:0] address;
    logic [5:0]  slot;
  } in_item_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [6:0]             pad;
    logic [CNT_W-1:0]       usage_now;
    logic [RULE_IDX_W-1:0]  rule_hit;
    logic [CLASS_IDX_W-1:0] class_out;
  } out_item_t;

  // rule table write port
  typedef struct packed {
    logic                  en;
    logic [RULE_IDX_W-1:0] idx;
    rule_t                 data;
  } rule_wr_t;

  // scan request from the controller
  typedef struct packed {
    logic        start;
    logic [31:0] addr;
    logic [4:0]  hour;
    logic [2:0]  wday;
  } scan_req_t;

  // scan answer, valid while done is high
  typedef struct packed {
    logic                   done;
    logic                   hit;
    logic [RULE_IDX_W-1:0]  idx;
    logic [CLASS_IDX_W-1:0] cls;
  } scan_rsp_t;

endpackage

[src/fmal_rule_scan.sv]
// Rule table memory and the sequential first-match scan over it.
// Depends on fmal_pkg.
module fmal_rule_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [6:0]            rules_in_use,
  input  fmal_pkg::rule_wr_t    rule_wr,
  input  fmal_pkg::scan_req_t   req,
  output fmal_pkg::scan_rsp_t   rsp
);

  fmal_pkg::rule_t rule_mem [fmal_pkg::RULE_COUNT];
  fmal_pkg::rule_t rd_data;

  logic                            busy;
  logic                            pend;
  logic [fmal_pkg::RULE_IDX_W:0]   rd_idx;
  logic [fmal_pkg::RULE_IDX_W-1:0] pend_idx;
  logic [fmal_pkg::RULE_IDX_W:0]   lim;
  logic [31:0]                     addr_q;
  logic [4:0]                      hour_q;
  logic [2:0]                      wday_q;

  logic [31:0] hours_ext;
  logic [7:0]  days_ext;
  logic        addr_ok;
  logic        time_ok;
  logic        match;
  logic        issuing;

  // compare the entry read last cycle
  always_comb begin
    hours_ext = {8'd0, rd_data.hours};
    days_ext  = {1'b0, rd_data.days};
    addr_ok   = ((rd_data.addr ^ addr_q) & rd_data.mask) == 32'd0;
    // hours above 23 and weekday 7 land on zero bits
    time_ok   = hours_ext[hour_q] && days_ext[wday_q];
    match     = pend && addr_ok && (!rd_data.timed || time_ok);
    issuing   = busy && !match && (rd_idx < lim);
  end

  assign rsp.done = busy && (match || (!issuing && !pend));
  assign rsp.hit  = match;
  assign rsp.idx  = match ? pend_idx : '0;
  assign rsp.cls  = match ? rd_data.cls : '0;

  // rule memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (rule_wr.en) begin
      rule_mem[rule_wr.idx] <= rule_wr.data;
    end
    if (issuing) begin
      rd_data <= rule_mem[rd_idx[fmal_pkg::RULE_IDX_W-1:0]];
    end
  end

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pend   <= 1'b0;
      rd_idx <= '0;
    end else if (req.start) begin
      busy   <= 1'b1;
      pend   <= 1'b0;
      rd_idx <= '0;
    end else if (rsp.done) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= issuing;
      if (issuing) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // request and index registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      addr_q <= req.addr;
      hour_q <= req.hour;
      wday_q <= req.wday;
      lim    <= (rules_in_use > 7'(fmal_pkg::RULE_COUNT)) ?
                (fmal_pkg::RULE_IDX_W+1)'(fmal_pkg::RULE_COUNT) : rules_in_use;
    end
    if (issuing) begin
      pend_idx <= rd_idx[fmal_pkg::RULE_IDX_W-1:0];
    end
  end

endmodule

[src/first_match_access_limiter.sv]
// First-match access limiter: command decode, class counter memory and result register.
// Check and recount run the rule scan, which reads one rule memory entry per cycle over
// up to the first rules_in_use entries (at most 64); loads and release do not scan.
// One command at a time; the next is taken once the previous one has reached the
// output register. Sync reset clears control, rules_in_use and all class valid bits.
module first_match_access_limiter (
  input  logic         clk,
  input  logic         rst,
  // config: rules_in_use
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  // input: slot, address, addr_mask, hour_set, day_set, time_check, rule_class,
  //        class_limit, hour_now, weekday_now, zero pad
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic [2:0]   s_tuser,   // cmd
  // output: class_out, rule_hit, usage_now, zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,
  output logic [1:0]   m_tuser    // status
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CUPD = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [fmal_pkg::CNT_W-1:0] limit;
    logic [fmal_pkg::CNT_W-1:0] usage;
  } class_ent_t;

  localparam logic [fmal_pkg::CNT_W-1:0] CNT_MAX = '1;

  state_t state;
  state_t state_next;

  logic [6:0] rules_in_use;

  fmal_pkg::in_item_t  item;
  fmal_pkg::cmd_t      cmd;
  fmal_pkg::rule_wr_t  rule_wr;
  fmal_pkg::scan_req_t scan_req;
  fmal_pkg::scan_rsp_t scan_rsp;

  logic accept;
  logic slot_is_class;

  // class memory with per-entry valid bits
  class_ent_t                          cls_mem [fmal_pkg::CLASS_COUNT];
  logic [fmal_pkg::CLASS_COUNT-1:0]    cls_vld;
  class_ent_t                          cls_rd_data;
  logic                                cls_rd_vld;
  logic                                cls_rd_en;
  logic [fmal_pkg::CLASS_IDX_W-1:0]    cls_rd_idx;
  logic                                cls_wr_en;
  logic [fmal_pkg::CLASS_IDX_W-1:0]    cls_wr_idx;
  class_ent_t                          cls_wr_data;

  // command context
  fmal_pkg::cmd_t                     cmd_q;
  logic [fmal_pkg::RULE_IDX_W-1:0]    hit_q;
  logic [fmal_pkg::CLASS_IDX_W-1:0]   cls_q;

  // pending result
  fmal_pkg::status_t                  res_status;
  logic [fmal_pkg::CLASS_IDX_W-1:0]   res_class;
  logic [fmal_pkg::RULE_IDX_W-1:0]    res_hit;
  logic [fmal_pkg::CNT_W-1:0]         res_usage;

  // class update datapath
  logic [fmal_pkg::CNT_W-1:0] cur_limit;
  logic [fmal_pkg::CNT_W-1:0] cur_usage;
  logic [fmal_pkg::CNT_W-1:0] new_usage;
  fmal_pkg::status_t          upd_status;

  fmal_pkg::out_item_t out_item;

  assign item          = fmal_pkg::in_item_t'(s_tdata);
  assign cmd           = fmal_pkg::cmd_t'(s_tuser);
  assign s_tready      = (state == ST_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign cfg_ready     = 1'b1;
  assign slot_is_class = item.slot < 6'(fmal_pkg::CLASS_COUNT);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rules_in_use <= cfg_data;
    end
  end

  // rule scan unit
  always_comb begin
    rule_wr.en         = accept && (cmd == fmal_pkg::CMD_LOAD_RULE);
    rule_wr.idx        = item.slot;
    rule_wr.data.addr  = item.address;
    rule_wr.data.mask  = item.addr_mask;
    rule_wr.data.hours = item.hour_set;
    rule_wr.data.days  = item.day_set;
    rule_wr.data.timed = item.time_check;
    rule_wr.data.cls   = item.rule_class;
    scan_req.start     = accept && (cmd == fmal_pkg::CMD_CHECK || cmd == fmal_pkg::CMD_RECOUNT);
    scan_req.addr      = item.address;
    scan_req.hour      = item.hour_now;
    scan_req.wday      = item.weekday_now;
  end

  fmal_rule_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .rules_in_use (rules_in_use),
    .rule_wr      (rule_wr),
    .req          (scan_req),
    .rsp          (scan_rsp)
  );

  // class update: an entry never loaded reads as zero
  always_comb begin
    cur_limit  = cls_rd_vld ? cls_rd_data.limit : '0;
    cur_usage  = cls_rd_vld ? cls_rd_data.usage : '0;
    new_usage  = cur_usage;
    upd_status = fmal_pkg::ST_GRANT;
    case (cmd_q)
      fmal_pkg::CMD_CHECK: begin
        if (cur_usage >= cur_limit) begin
          upd_status = fmal_pkg::ST_FULL;
        end else begin
          new_usage = cur_usage + 1'b1;
        end
      end
      fmal_pkg::CMD_RECOUNT: begin
        if (cur_usage != CNT_MAX) begin
          new_usage = cur_usage + 1'b1;
        end
      end
      default: begin
        // release saturates at zero
        upd_status = fmal_pkg::ST_DONE;
        if (cur_usage != '0) begin
          new_usage = cur_usage - 1'b1;
        end
      end
    endcase
  end

  // class memory port control
  always_comb begin
    cls_rd_en         = 1'b0;
    cls_rd_idx        = item.slot[fmal_pkg::CLASS_IDX_W-1:0];
    cls_wr_en         = 1'b0;
    cls_wr_idx        = cls_q;
    cls_wr_data.limit = cur_limit;
    cls_wr_data.usage = new_usage;
    if (state == ST_IDLE) begin
      cls_wr_idx        = item.slot[fmal_pkg::CLASS_IDX_W-1:0];
      cls_wr_data.limit = item.class_limit;
      cls_wr_data.usage = '0;
      cls_wr_en         = accept && (cmd == fmal_pkg::CMD_LOAD_CLASS) && slot_is_class;
      cls_rd_en         = accept && (cmd == fmal_pkg::CMD_RELEASE) && slot_is_class;
    end else if (state == ST_SCAN) begin
      cls_rd_idx = scan_rsp.cls;
      cls_rd_en  = scan_rsp.done && scan_rsp.hit;
    end else if (state == ST_CUPD) begin
      cls_wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cls_wr_en) begin
      cls_mem[cls_wr_idx] <= cls_wr_data;
    end
    if (cls_rd_en) begin
      cls_rd_data <= cls_mem[cls_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_vld    <= '0;
      cls_rd_vld <= 1'b0;
    end else begin
      if (cls_wr_en) begin
        cls_vld[cls_wr_idx] <= 1'b1;
      end
      if (cls_rd_en) begin
        cls_rd_vld <= cls_vld[cls_rd_idx];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (scan_req.start) begin
            state_next = ST_SCAN;
          end else if (cls_rd_en) begin
            state_next = ST_CUPD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_next = scan_rsp.hit ? ST_CUPD : ST_OUT;
        end
      end
      ST_CUPD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command context and pending result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cmd_q      <= cmd;
      hit_q      <= '0;
      cls_q      <= item.slot[fmal_pkg::CLASS_IDX_W-1:0];
      res_status <= fmal_pkg::ST_DONE;
      res_class  <= '0;
      res_hit    <= '0;
      res_usage  <= '0;
    end else if (state == ST_SCAN && scan_rsp.done) begin
      hit_q      <= scan_rsp.idx;
      cls_q      <= scan_rsp.cls;
      res_status <= fmal_pkg::ST_NONE;
      res_class  <= '0;
      res_hit    <= '0;
      res_usage  <= '0;
    end else if (state == ST_CUPD) begin
      res_status <= upd_status;
      res_class  <= cls_q;
      res_hit    <= hit_q;
      res_usage  <= new_usage;
    end
  end

  // output register
  always_comb begin
    out_item.pad       = '0;
    out_item.usage_now = res_usage;
    out_item.rule_hit  = res_hit;
    out_item.class_out = res_class;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= out_item;
      m_tuser <= res_status;
    end
  end

`ifndef NO_ASSERTIONS
  // the scan unit answers only while the controller waits for it
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_rsp.done |-> state == ST_SCAN)
    else $error("scan answer outside of scan state");

  // an accepted command always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted command did not start");

  // a finished result waits while the output register is still full
  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_tvalid && !m_tready) |=> state == ST_OUT)
    else $error("result dropped while output busy");
`endif

endmodule

[verif/fmal_verdict_monitor.sv]
// Watches the config, command and result streams of first_match_access_limiter,
// predicts each result from its own copy of the rule and class tables, and checks it.
// Depends on fmal_pkg for the stream layouts, command and status codes.
module fmal_verdict_monitor
  import fmal_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [6:0]   cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,   // slot, address, addr_mask, hour_set, day_set,
                                  // time_check, rule_class, class_limit, hour_now,
                                  // weekday_now, zero pad
  input  logic [2:0]   s_tuser,   // cmd
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,   // class_out, rule_hit, usage_now, zero pad
  input  logic [1:0]   m_tuser,   // status
  output int           n_errors,
  output int           n_pending,
  output int           n_granted,
  output int           n_full,
  output int           n_none
);

  localparam int HOUR_MAX = 23;
  localparam int LAST_DAY  = 6;
  localparam int REPORT_MAX = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    status_t                st;
    logic [CLASS_IDX_W-1:0] cls;
    logic [RULE_IDX_W-1:0]  hit;
    logic [CNT_W-1:0]       usage;
  } verdict_t;

  // shadow tables; rule slots are never scanned before they are loaded
  rule_t            rule_tbl   [RULE_COUNT];
  logic [CNT_W-1:0] class_cap  [CLASS_COUNT];
  logic [CNT_W-1:0] class_used [CLASS_COUNT];
  logic [6:0]       scan_len;
  verdict_t         verdicts_due [$];

  // address agrees under the mask; timed rules also need hour and weekday bits
  function automatic logic rule_matches(rule_t r, logic [31:0] a, logic [4:0] hr,
                                        logic [2:0] wd);
    if (((r.addr ^ a) & r.mask) != '0) return 1'b0;
    if (!r.timed) return 1'b1;
    if (hr > HOUR_MAX || wd > LAST_DAY) return 1'b0;
    return r.hours[hr] && r.days[wd];
  endfunction

  // apply one command to the shadow state and work out its result
  task automatic predict_verdict(input logic [2:0] code, input in_item_t it,
                                 output verdict_t v);
    int n;
    int hit;
    logic [CLASS_IDX_W-1:0] c;
    v = '0;
    v.st = ST_DONE;
    case (code)
      CMD_LOAD_RULE: begin
        rule_tbl[it.slot] = '{addr: it.address, mask: it.addr_mask, hours: it.hour_set,
                              days: it.day_set, timed: it.time_check, cls: it.rule_class};
      end
      CMD_LOAD_CLASS: begin
        if (it.slot < CLASS_COUNT) begin
          class_cap[it.slot[CLASS_IDX_W-1:0]]  = it.class_limit;
          class_used[it.slot[CLASS_IDX_W-1:0]] = '0;
        end
      end
      CMD_CHECK, CMD_RECOUNT: begin
        n = (scan_len > RULE_COUNT) ? RULE_COUNT : int'(scan_len);
        hit = -1;
        for (int i = 0; i < n && hit < 0; i++) begin
          if (rule_matches(rule_tbl[i], it.address, it.hour_now, it.weekday_now)) hit = i;
        end
        if (hit < 0) begin
          v.st = ST_NONE;
        end else begin
          c = rule_tbl[hit].cls;
          v.cls = c;
          v.hit = RULE_IDX_W'(hit);
          // check honors the limit, recount only saturates
          if (code == CMD_CHECK && class_used[c] >= class_cap[c]) begin
            v.st = ST_FULL;
          end else begin
            v.st = ST_GRANT;
            if (class_used[c] != CNT_MAX) class_used[c]++;
          end
          v.usage = class_used[c];
        end
      end
      CMD_RELEASE: begin
        if (it.slot < CLASS_COUNT) begin
          c = it.slot[CLASS_IDX_W-1:0];
          if (class_used[c] != '0) class_used[c]--;
          v.cls   = c;
          v.usage = class_used[c];
        end
      end
      default: ;
    endcase
  endtask

  // predict on each command transfer, compare on each result transfer
  always @(posedge clk) begin : watch
    verdict_t  want;
    out_item_t got;
    if (rst) begin
      scan_len = '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        class_cap[k]  = '0;
        class_used[k] = '0;
      end
      verdicts_due.delete();
      n_errors  = 0;
      n_pending = 0;
      n_granted = 0;
      n_full    = 0;
      n_none    = 0;
    end else begin
      if (cfg_valid && cfg_ready) scan_len = cfg_data;
      if (s_tvalid && s_tready) begin
        predict_verdict(s_tuser, in_item_t'(s_tdata), want);
        verdicts_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (verdicts_due.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("unexpected result: status %0d class %0d rule %0d usage %0d",
                     m_tuser, got.class_out, got.rule_hit, got.usage_now);
        end else begin
          want = verdicts_due.pop_front();
          case (want.st)
            ST_GRANT: n_granted++;
            ST_FULL:  n_full++;
            ST_NONE:  n_none++;
            default:  ;
          endcase
          if (m_tuser !== want.st || got.class_out !== want.cls ||
              got.rule_hit !== want.hit || got.usage_now !== want.usage) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display({"mismatch: exp status %0d class %0d rule %0d usage %0d,",
                        " got %0d %0d %0d %0d"},
                       want.st, want.cls, want.hit, want.usage,
                       m_tuser, got.class_out, got.rule_hit, got.usage_now);
          end
        end
      end
      n_pending = verdicts_due.size();
    end
  end

endmodule

[verif/tb_first_match_access_limiter.sv]
// Stimulus and verdict for first_match_access_limiter: directed lookups, then random
// command mixes over several rules_in_use settings. Uses fmal_pkg and fmal_verdict_monitor.
module tb_first_match_access_limiter;
  import fmal_pkg::*;

  localparam int GAP_MAX      = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 292;
  localparam int HOLD_PHASE   = 2;
  localparam int HOLD_AT      = 100;
  localparam int HOUR_MAX     = 23;
  localparam int LAST_DAY     = 6;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam logic [30:0] LIMIT_OPEN    = '1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [6:0]   cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;

  int n_errors, n_pending, n_granted, n_full, n_none;
  int n_sent, n_lookups, n_cfg;
  int scan_now;
  int rx_wait;
  bit tx_quiet, rx_quiet, hold_go;
  logic rx_hold = 1'b0;

  // what the stimulus has loaded, used to aim lookups at live rules
  logic [31:0] rule_addr_seen [RULE_COUNT];
  logic [31:0] rule_mask_seen [RULE_COUNT];

  first_match_access_limiter dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fmal_verdict_monitor monitor (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .n_errors(n_errors), .n_pending(n_pending),
    .n_granted(n_granted), .n_full(n_full), .n_none(n_none)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hang guard
  initial begin
    #2000000;
    $display("tb_first_match_access_limiter: errors");
    $finish;
  end

  // result side: random stalls per transfer, quiet stretches, one long hold
  always @(posedge clk) begin : rx_side
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      if ($urandom_range(0, 63) == 0) rx_quiet <= !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (rx_hold || gap != 0) begin
        m_tready <= 1'b0;
        rx_wait  <= gap;
      end
    end else if (m_tready && rx_hold) begin
      m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_wait != 0) rx_wait <= rx_wait - 1;
      else if (!rx_hold) m_tready <= 1'b1;
    end
  end

  // long hold on the result side while commands keep coming
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // one command transfer, after a random gap
  task automatic send_cmd(input logic [2:0] code, input in_item_t it);
    int gap;
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (code == CMD_CHECK || code == CMD_RECOUNT) n_lookups++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // rules_in_use write, only with the block idle
  task automatic set_scan(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 7'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    scan_now = (v > RULE_COUNT) ? RULE_COUNT : v;
    n_cfg++;
  endtask

  // every field but the zero pad random, so unused fields still toggle
  function automatic in_item_t noise_item();
    in_item_t it;
    it = '0;
    it.slot        = 6'($urandom_range(0, RULE_COUNT - 1));
    it.address     = $urandom;
    it.addr_mask   = $urandom;
    it.hour_set    = 24'($urandom);
    it.day_set     = 7'($urandom);
    it.time_check  = 1'($urandom);
    it.rule_class  = 4'($urandom);
    it.class_limit = 31'($urandom);
    it.hour_now    = 5'($urandom_range(0, 31));
    it.weekday_now = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // mostly prefix masks; a catch-all only when timed, so deep rules stay reachable
  function automatic in_item_t random_rule();
    in_item_t it;
    int kind;
    it = noise_item();
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      it.addr_mask = 32'hffff_ffff << (32 - $urandom_range(8, 32));
    end else if (kind < 78) begin
      it.addr_mask  = '0;
      it.time_check = 1'b1;
    end
    return it;
  endfunction

  // lookup aimed at a live rule most of the time, with mostly valid hour and day
  function automatic in_item_t aimed(input in_item_t it);
    int j;
    if (scan_now > 0 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, scan_now - 1);
      it.address = rule_addr_seen[j] ^ ($urandom & ~rule_mask_seen[j]);
    end
    it.hour_now    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(HOUR_MAX + 1, 31))
                                                 : 5'($urandom_range(0, HOUR_MAX));
    it.weekday_now = ($urandom_range(0, 9) == 0) ? 3'(LAST_DAY + 1)
                                                 : 3'($urandom_range(0, LAST_DAY));
    return it;
  endfunction

  task automatic load_rule(input int idx, input in_item_t it);
    it.slot = 6'(idx);
    rule_addr_seen[idx] = it.address;
    rule_mask_seen[idx] = it.addr_mask;
    send_cmd(CMD_LOAD_RULE, it);
  endtask

  task automatic load_class(input int idx, input logic [30:0] lim);
    in_item_t it;
    it = noise_item();
    it.slot        = 6'(idx);
    it.class_limit = lim;
    send_cmd(CMD_LOAD_CLASS, it);
  endtask

  task automatic lookup(input logic [2:0] code, input logic [31:0] a, input int hr,
                        input int wd);
    in_item_t it;
    it = noise_item();
    it.address     = a;
    it.hour_now    = 5'(hr);
    it.weekday_now = 3'(wd);
    send_cmd(code, it);
  endtask

  task automatic release_class(input int idx);
    in_item_t it;
    it = noise_item();
    it.slot = 6'(idx);
    send_cmd(CMD_RELEASE, it);
  endtask

  // mostly small limits so refusals and releases matter
  function automatic logic [30:0] random_limit();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 31'($urandom_range(0, 6));
    if (sel < 9) return 31'($urandom);
    return LIMIT_OPEN;
  endfunction

  task automatic random_cmd();
    in_item_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_cmd(CMD_CHECK, aimed(it));
    end else if (pick < 57) begin
      send_cmd(CMD_RECOUNT, aimed(it));
    end else if (pick < 73) begin
      if ($urandom_range(0, 4) != 0) it.slot = 6'($urandom_range(0, CLASS_COUNT - 1));
      send_cmd(CMD_RELEASE, it);
    end else if (pick < 85) begin
      load_rule($urandom_range(0, RULE_COUNT - 1), random_rule());
    end else if (pick < 97) begin
      load_class(($urandom_range(0, 4) != 0) ? $urandom_range(0, CLASS_COUNT - 1)
                                             : $urandom_range(0, RULE_COUNT - 1),
                 random_limit());
    end else begin
      send_cmd(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), it);
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    int scan_plan [6];
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty scan: lookups find nothing; ignored slots and unknown codes
    set_scan(0);
    lookup(CMD_CHECK, 32'h0, 0, 0);
    lookup(CMD_RECOUNT, 32'hffff_ffff, 31, 7);
    release_class(0);
    release_class(RULE_COUNT - 1);
    load_class(RULE_COUNT - 1, LIMIT_OPEN);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_cmd(3'(c), noise_item());
    load_class(0, 31'd2);
    load_class(1, 31'd0);
    load_class(CLASS_COUNT - 1, LIMIT_OPEN);

    // timed subnet rule, exact host rule, catch-all
    it = noise_item();
    it.address = 32'hc0a8_0000;  it.addr_mask = 32'hffff_0000;
    it.hour_set = 24'h80_0001;   it.day_set = 7'h41;
    it.time_check = 1'b1;        it.rule_class = 4'd0;
    load_rule(0, it);
    it = noise_item();
    it.address = 32'hffff_ffff;  it.addr_mask = 32'hffff_ffff;
    it.time_check = 1'b0;        it.rule_class = 4'(CLASS_COUNT - 1);
    load_rule(1, it);
    it = noise_item();
    it.addr_mask = '0;  it.time_check = 1'b0;  it.rule_class = 4'd1;
    load_rule(2, it);

    // first match, limit, recount past limit, out-of-range hour and day
    set_scan(3);
    lookup(CMD_CHECK, 32'hc0a8_1234, 0, 0);
    lookup(CMD_CHECK, 32'hc0a8_ffff, HOUR_MAX, LAST_DAY);
    lookup(CMD_CHECK, 32'hc0a8_ffff, HOUR_MAX, LAST_DAY);
    lookup(CMD_RECOUNT, 32'hc0a8_ffff, HOUR_MAX, LAST_DAY);
    lookup(CMD_CHECK, 32'hc0a8_0001, HOUR_MAX + 1, 0);
    lookup(CMD_CHECK, 32'hc0a8_0001, 0, LAST_DAY + 1);
    lookup(CMD_CHECK, 32'hc0a8_0001, 12, 3);
    lookup(CMD_CHECK, 32'hffff_ffff, 31, 7);
    release_class(0);
    release_class(CLASS_COUNT - 1);
    release_class(CLASS_COUNT - 1);

    // fill the remaining rule slots and all classes
    for (int i = 3; i < RULE_COUNT; i++) load_rule(i, random_rule());
    for (int c = 0; c < CLASS_COUNT; c++) load_class(c, random_limit());

    // random mixes over full, minimal, oversized and mid-range scans
    scan_plan = '{RULE_COUNT, 1, 127, $urandom_range(2, RULE_COUNT - 1),
                  $urandom_range(RULE_COUNT + 1, 126), RULE_COUNT};
    for (int ph = 0; ph < 6; ph++) begin
      set_scan(scan_plan[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == HOLD_PHASE && k == HOLD_AT) hold_go = 1'b1;
        random_cmd();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d commands, %0d lookups, %0d rules_in_use writes",
             n_sent, n_lookups, n_cfg);
    $display("summary: %0d granted, %0d refused full, %0d unmatched",
             n_granted, n_full, n_none);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_first_match_access_limiter: clean");
    end else begin
      $display("tb_first_match_access_limiter: errors");
    end
    $finish;
  end

endmodule
